>>> rtl/core/otsu_pkg.sv
// shared types and constants for the otsu threshold finder
`timescale 1ns / 1ps
package otsu_pkg;
	localparam int BINS_DEF = 256;
	localparam int COUNT_BITS_DEF = 24;

	typedef struct packed {
		logic [7:0] pixel;
		logic       last_pixel;
	} in_item_t;

	typedef struct packed {
		logic [7:0] threshold;
		logic       overflow;
	} out_item_t;

	typedef enum logic [3:0] {
		B_IDLE, B_RD, B_ACC, B_MUL1, B_DIFF, B_SQ, B_LHS, B_RHS, B_CMP, B_CLR, B_OUT
	} back_state_t;
endpackage

>>> rtl/core/otsu_threshold_finder.sv
// top level of the otsu threshold finder
`timescale 1ns / 1ps
// Pixels are taken one per cycle, while the back end is idle, into a histogram
// of BINS counters through a two-entry input queue; a counter read-modify-write
// with forwarding keeps that rate. Right after reset the histogram is cleared
// one bin per cycle, and no pixel is taken meanwhile. After the pixel marked
// last the block scans every bin: it reads the bin, accumulates and forms the
// class products and their difference, then, unless a class is empty, builds
// three wide products from 32 by 32 bit limb steps (at the default widths eight
// steps each), and compares. It then clears the histogram one bin per cycle and
// holds its one result until it is taken, and only then takes new pixels again.
module otsu_threshold_finder #(
	parameter int BINS = otsu_pkg::BINS_DEF,
	parameter int COUNT_BITS = otsu_pkg::COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  otsu_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output otsu_pkg::out_item_t out_data
);
	logic               q_valid, q_ready;
	otsu_pkg::in_item_t q_data;

	otsu_fifo #(.W($bits(otsu_pkg::in_item_t))) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
	);

	otsu_back #(.BINS(BINS), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);
endmodule

>>> rtl/core/otsu_fifo.sv
// small queue between histogram front end and search back end
`timescale 1ns / 1ps
module otsu_fifo #(
	parameter int W = 9
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);
	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;

	assign in_ready  = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) mem_q[wp_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (out_valid && out_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, in_valid && in_ready} - {1'b0, out_valid && out_ready};
		end
	end
endmodule

>>> rtl/core/otsu_back.sv
// histogram memory, accumulation and threshold search
`timescale 1ns / 1ps
module otsu_back #(
	parameter int BINS = otsu_pkg::BINS_DEF,
	parameter int COUNT_BITS = otsu_pkg::COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_ready,
	input  otsu_pkg::in_item_t  q_data,
	output logic                out_valid,
	input  logic                out_ready,
	output otsu_pkg::out_item_t out_data
);
	localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
	localparam int SW = 32;
	localparam int S0W = SW;
	localparam int DW = COUNT_BITS + SW;
	localparam int NW = 2 * DW;
	localparam int EW = 2 * COUNT_BITS;
	localparam int PW = NW + EW;
	localparam int BMAX = (DW > EW) ? DW : EW;
	localparam int NAL = (NW + 31) / 32;
	localparam int NBL = (BMAX + 31) / 32;
	localparam int AXW = 32 * NAL;
	localparam int BXW = 32 * NBL;
	localparam int IW = (NAL > 1) ? $clog2(NAL) : 1;
	localparam int JW = (NBL > 1) ? $clog2(NBL) : 1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [AW:0] T_LAST = (AW+1)'(BINS - 1);

	// histogram read-modify-write pipeline with forwarding
	logic [COUNT_BITS-1:0] hist_q [BINS];
	logic [COUNT_BITS-1:0] rd_q;
	logic [AW-1:0]         rd_addr_q;
	logic                  wr_s1;
	logic [AW-1:0]         addr_s1;
	logic                  last_s1;
	logic [COUNT_BITS-1:0] wr_val;
	logic                  fwd_s2;
	logic [COUNT_BITS-1:0] wv_s2;
	logic [AW-1:0]         wa_s2;

	logic [COUNT_BITS-1:0] total_q;
	logic [SW-1:0]         sum_q;
	logic                  ovf_q;
	logic                  init_q;

	otsu_pkg::back_state_t st_q, st_d;
	logic [AW:0]           t_q;
	logic [COUNT_BITS-1:0] w0_q;
	logic [S0W-1:0]        s0_q;
	logic [DW-1:0]         pa_q, pb_q;
	logic [DW-1:0]         d_q;
	logic [EW-1:0]         den_q;
	logic [NW-1:0]         num_q, bnum_q;
	logic [EW-1:0]         bden_q;
	logic [PW-1:0]         lhs_q, rhs_q;
	logic [AW:0]           best_q;
	logic                  skip_q;
	logic [7:0]            res_q;

	// limb-serial wide multiplier
	logic [IW-1:0]         mi_q;
	logic [JW-1:0]         mj_q;
	logic [PW-1:0]         acc_q;
	logic [AXW-1:0]        ma;
	logic [BXW-1:0]        mb;
	logic [63:0]           part;
	logic [PW-1:0]         acc_sum;
	logic                  mul_on;
	logic                  mul_last;

	logic [AW-1:0] lvl;
	logic          accept;
	logic [AW-1:0] mem_addr;
	logic          mem_we;
	logic [COUNT_BITS-1:0] mem_wd;
	logic [COUNT_BITS-1:0] cur;

	assign lvl = (q_data.pixel >= BINS) ? AW'(BINS - 1) : AW'(q_data.pixel);
	assign q_ready = (st_q == otsu_pkg::B_IDLE) && !last_s1;
	assign accept = q_valid && q_ready;
	assign cur = (fwd_s2 && wa_s2 == addr_s1) ? wv_s2 : rd_q;
	assign wr_val = cur + COUNT_BITS'(1);

	always_comb begin
		ma = AXW'(bnum_q);
		mb = BXW'(den_q);
		case (st_q)
			otsu_pkg::B_SQ: begin
				ma = AXW'(d_q);
				mb = BXW'(d_q);
			end
			otsu_pkg::B_LHS: begin
				ma = AXW'(num_q);
				mb = BXW'(bden_q);
			end
			default: ;
		endcase
	end

	assign part = 64'(ma[32*mi_q +: 32]) * 64'(mb[32*mj_q +: 32]);
	assign acc_sum = acc_q + (PW'(part) << (32 * (int'(mi_q) + int'(mj_q))));
	assign mul_on = (st_q == otsu_pkg::B_SQ) || (st_q == otsu_pkg::B_LHS) ||
		(st_q == otsu_pkg::B_RHS);
	assign mul_last = (mi_q == IW'(NAL - 1)) && (mj_q == JW'(NBL - 1));

	always_comb begin
		mem_addr = lvl;
		mem_we = wr_s1;
		mem_wd = wr_val;
		if (st_q != otsu_pkg::B_IDLE) mem_addr = t_q[AW-1:0];
		if (st_q == otsu_pkg::B_CLR) begin
			mem_we = 1'b1;
			mem_wd = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) hist_q[(st_q == otsu_pkg::B_CLR) ? t_q[AW-1:0] : addr_s1] <= mem_wd;
		rd_q <= hist_q[mem_addr];
		rd_addr_q <= mem_addr;
		wv_s2 <= wr_val;
		wa_s2 <= addr_s1;
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			otsu_pkg::B_IDLE: if (last_s1) st_d = otsu_pkg::B_RD;
			otsu_pkg::B_RD:   st_d = otsu_pkg::B_ACC;
			otsu_pkg::B_ACC:  st_d = otsu_pkg::B_MUL1;
			otsu_pkg::B_MUL1: st_d = otsu_pkg::B_DIFF;
			otsu_pkg::B_DIFF: st_d = skip_q ? otsu_pkg::B_CMP : otsu_pkg::B_SQ;
			otsu_pkg::B_SQ:   if (mul_last) st_d = otsu_pkg::B_LHS;
			otsu_pkg::B_LHS:  if (mul_last) st_d = otsu_pkg::B_RHS;
			otsu_pkg::B_RHS:  if (mul_last) st_d = otsu_pkg::B_CMP;
			otsu_pkg::B_CMP:  st_d = (t_q == T_LAST) ? otsu_pkg::B_CLR : otsu_pkg::B_RD;
			otsu_pkg::B_CLR: begin
				if (t_q == '0) st_d = init_q ? otsu_pkg::B_IDLE : otsu_pkg::B_OUT;
			end
			otsu_pkg::B_OUT:  if (out_ready) st_d = otsu_pkg::B_IDLE;
			default:          st_d = otsu_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		out_valid = st_q == otsu_pkg::B_OUT;
		out_data.threshold = res_q;
		out_data.overflow = ovf_q;
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			otsu_pkg::B_MUL1: begin
				skip_q <= (w0_q == '0) || (w0_q >= total_q);
				pa_q <= DW'(total_q) * DW'(s0_q);
				pb_q <= DW'(sum_q) * DW'(w0_q);
				den_q <= EW'(w0_q) * EW'(total_q - w0_q);
			end
			otsu_pkg::B_DIFF: d_q <= (pa_q >= pb_q) ? pa_q - pb_q : pb_q - pa_q;
			otsu_pkg::B_SQ:   if (mul_last) num_q <= NW'(acc_sum);
			otsu_pkg::B_LHS:  if (mul_last) lhs_q <= acc_sum;
			otsu_pkg::B_RHS:  if (mul_last) rhs_q <= acc_sum;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= otsu_pkg::B_CLR;
			init_q <= 1'b1;
			wr_s1 <= 1'b0;
			last_s1 <= 1'b0;
			fwd_s2 <= 1'b0;
			total_q <= '0;
			sum_q <= '0;
			ovf_q <= 1'b0;
			t_q <= T_LAST;
			w0_q <= '0;
			s0_q <= '0;
			bnum_q <= '0;
			bden_q <= EW'(1);
			best_q <= '0;
			res_q <= '0;
			addr_s1 <= '0;
			acc_q <= '0;
			mi_q <= '0;
			mj_q <= '0;
		end else begin
			st_q <= st_d;
			fwd_s2 <= wr_s1;
			wr_s1 <= 1'b0;
			if (accept) begin
				last_s1 <= q_data.last_pixel;
				addr_s1 <= lvl;
				if (total_q == CNT_MAX) ovf_q <= 1'b1;
				else begin
					wr_s1 <= 1'b1;
					total_q <= total_q + COUNT_BITS'(1);
					if ({1'b0, sum_q} + (SW+1)'(lvl) > (SW+1)'({SW{1'b1}})) begin
						sum_q <= {SW{1'b1}};
						ovf_q <= 1'b1;
					end else sum_q <= sum_q + SW'(lvl);
				end
			end else if (st_q == otsu_pkg::B_IDLE) last_s1 <= 1'b0;
			if (st_q == otsu_pkg::B_ACC) begin
				w0_q <= w0_q + rd_q;
				s0_q <= s0_q + S0W'(rd_q) * S0W'(rd_addr_q);
			end
			if (mul_on) begin
				acc_q <= mul_last ? '0 : acc_sum;
				if (mj_q == JW'(NBL - 1)) begin
					mj_q <= '0;
					mi_q <= (mi_q == IW'(NAL - 1)) ? '0 : mi_q + IW'(1);
				end else mj_q <= mj_q + JW'(1);
			end
			if (st_q == otsu_pkg::B_CMP) begin
				if (!skip_q && lhs_q > rhs_q) begin
					bnum_q <= num_q;
					bden_q <= den_q;
					best_q <= t_q;
				end
				t_q <= (t_q == T_LAST) ? t_q : t_q + (AW+1)'(1);
			end
			if (st_q == otsu_pkg::B_CLR) begin
				t_q <= (t_q == '0) ? t_q : t_q - (AW+1)'(1);
				if (t_q == '0) begin
					init_q <= 1'b0;
					res_q <= best_q[7:0];
					total_q <= '0;
					sum_q <= '0;
					w0_q <= '0;
					s0_q <= '0;
					bnum_q <= '0;
					bden_q <= EW'(1);
					best_q <= '0;
				end
			end
			if (st_q == otsu_pkg::B_OUT && out_ready) ovf_q <= 1'b0;
		end
	end
endmodule
